>>> rtl/tsrp_pkg.sv
// Shared types and constants for the tab-separated record parser.
package tsrp_pkg;

   localparam int MAX_ENTRIES = 32;
   localparam int TITLE_CAP   = 31;
   localparam int VALUE_CAP   = 62;
   localparam int QUEUE_DEPTH = 4;

   localparam logic [7:0] CH_TAB = 8'h09;
   localparam logic [7:0] CH_LF  = 8'h0A;
   localparam logic [7:0] CH_CR  = 8'h0D;

   localparam logic [1:0] KIND_TITLE  = 2'd0;
   localparam logic [1:0] KIND_VALUE  = 2'd1;
   localparam logic [1:0] KIND_COMMIT = 2'd2;
   localparam logic [1:0] KIND_DONE   = 2'd3;

   localparam logic [2:0] CSR_MASK_0 = 3'd0;
   localparam logic [2:0] CSR_MASK_1 = 3'd1;
   localparam logic [2:0] CSR_MASK_2 = 3'd2;
   localparam logic [2:0] CSR_MASK_3 = 3'd3;

   typedef enum logic [1:0] {
      PH_TITLE = 2'd0,
      PH_VALUE = 2'd1,
      PH_SKIP  = 2'd2
   } phase_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_BURST,
      ST_VALUE,
      ST_COMMIT,
      ST_DONE
   } back_state_type;

   // One queue entry: every action caused by one accepted byte.
   typedef struct packed {
      logic       burst;
      logic       value;
      logic       commit;
      logic       done;
      logic [4:0] index;
      logic [4:0] burst_len;
      logic [5:0] vpos;
      logic [7:0] vdata;
      logic [4:0] tlen;
      logic [5:0] vlen;
      logic [5:0] total;
   } cmd_type;

endpackage

>>> rtl/tsrp_front.sv
// Front end: byte classification, line state, title buffer and mask registers.
module tsrp_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [7:0]             req_in_byte,
   input  logic                   req_in_last,
   input  logic                   csr_valid,
   input  logic [2:0]             csr_index,
   input  logic [63:0]            csr_data,
   input  logic                   q_full,
   output logic                   q_push,
   output tsrp_pkg::cmd_type      q_cmd,
   input  logic                   burst_finish,
   input  logic [4:0]             title_rd_idx,
   output logic [7:0]             title_rd_data
);

   logic [63:0]         mask_ff [4];
   logic [7:0]          tbuf_ff [tsrp_pkg::TITLE_CAP];
   tsrp_pkg::phase_type phase_ff, phase_in;
   logic [4:0]          tf_ff, tf_in;
   logic [5:0]          vf_ff, vf_in;
   logic [5:0]          cnt_ff, cnt_in;
   logic                burst_pend_ff, burst_pend_in;
   tsrp_pkg::cmd_type   cmd;
   logic                eol, active, write_title, accept;
   logic [4:0]          mpos;
   logic [63:0]         mword;

   assign eol    = (req_in_byte == tsrp_pkg::CH_LF) || (req_in_byte == tsrp_pkg::CH_CR);
   assign active = cnt_ff < 6'(tsrp_pkg::MAX_ENTRIES);
   assign write_title = active && !eol && (phase_ff == tsrp_pkg::PH_TITLE) &&
                        (req_in_byte != tsrp_pkg::CH_TAB) &&
                        (tf_ff < 5'(tsrp_pkg::TITLE_CAP));

   // Hold title bytes while the previous title still drains from the buffer.
   assign req_ready = !q_full && !(write_title && burst_pend_ff);
   assign accept    = req_valid && req_ready;

   assign mpos  = vf_ff[4:0];
   assign mword = mask_ff[mpos[4:3]];

   assign title_rd_data = tbuf_ff[title_rd_idx];

   always_comb begin
      phase_in = phase_ff;
      tf_in    = tf_ff;
      vf_in    = vf_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      cmd.index = cnt_ff[4:0];
      if (active) begin
         if (eol) begin
            if (phase_ff == tsrp_pkg::PH_VALUE) begin
               cmd.commit = 1'b1;
               cmd.tlen   = tf_ff;
               cmd.vlen   = vf_ff;
               cnt_in     = cnt_ff + 6'd1;
            end
            phase_in = tsrp_pkg::PH_TITLE;
            tf_in    = '0;
            vf_in    = '0;
         end else begin
            unique case (phase_ff)
               tsrp_pkg::PH_TITLE: begin
                  if (req_in_byte == tsrp_pkg::CH_TAB) begin
                     if (tf_ff == '0) begin
                        phase_in = tsrp_pkg::PH_SKIP;
                     end else begin
                        cmd.burst     = 1'b1;
                        cmd.burst_len = tf_ff;
                        phase_in      = tsrp_pkg::PH_VALUE;
                        vf_in         = '0;
                     end
                  end else if (tf_ff < 5'(tsrp_pkg::TITLE_CAP)) begin
                     tf_in = tf_ff + 5'd1;
                  end
               end
               tsrp_pkg::PH_VALUE: begin
                  if (vf_ff < 6'(tsrp_pkg::VALUE_CAP)) begin
                     cmd.value = 1'b1;
                     cmd.vpos  = vf_ff;
                     cmd.vdata = req_in_byte ^ mword[{mpos[2:0], 3'b000} +: 8];
                     vf_in     = vf_ff + 6'd1;
                  end
               end
               default: begin
                  // drop bytes until the line ends
               end
            endcase
         end
         if (req_in_last && (phase_in == tsrp_pkg::PH_VALUE) && !eol) begin
            cmd.commit = 1'b1;
            cmd.tlen   = tf_in;
            cmd.vlen   = vf_in;
            cnt_in     = cnt_ff + 6'd1;
         end
      end
      if (req_in_last) begin
         cmd.done  = 1'b1;
         cmd.total = cnt_in;
         phase_in  = tsrp_pkg::PH_TITLE;
         tf_in     = '0;
         vf_in     = '0;
         cnt_in    = '0;
      end
   end

   assign q_cmd  = cmd;
   assign q_push = accept && (cmd.burst || cmd.value || cmd.commit || cmd.done);

   always_comb begin
      burst_pend_in = burst_pend_ff;
      if (q_push && cmd.burst) begin
         burst_pend_in = 1'b1;
      end else if (burst_finish) begin
         burst_pend_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= tsrp_pkg::PH_TITLE;
         tf_ff         <= '0;
         vf_ff         <= '0;
         cnt_ff        <= '0;
         burst_pend_ff <= 1'b0;
         for (int i = 0; i < 4; i++) begin
            mask_ff[i] <= '0;
         end
      end else begin
         burst_pend_ff <= burst_pend_in;
         if (accept) begin
            phase_ff <= phase_in;
            tf_ff    <= tf_in;
            vf_ff    <= vf_in;
            cnt_ff   <= cnt_in;
         end
         if (csr_valid) begin
            unique case (csr_index)
               tsrp_pkg::CSR_MASK_0: mask_ff[0] <= csr_data;
               tsrp_pkg::CSR_MASK_1: mask_ff[1] <= csr_data;
               tsrp_pkg::CSR_MASK_2: mask_ff[2] <= csr_data;
               tsrp_pkg::CSR_MASK_3: mask_ff[3] <= csr_data;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && write_title) begin
         tbuf_ff[tf_ff] <= req_in_byte;
      end
   end

endmodule

>>> rtl/tsrp_queue.sv
// Command queue between the front end and the result sequencer.
module tsrp_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  tsrp_pkg::cmd_type push_cmd,
   output logic              full,
   input  logic              pop,
   output logic              not_empty,
   output tsrp_pkg::cmd_type head_cmd
);

   localparam int PTR_W = $clog2(tsrp_pkg::QUEUE_DEPTH);

   tsrp_pkg::cmd_type slot_ff [tsrp_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ff, rd_ff;
   logic [PTR_W:0]    fill_ff, fill_in;

   assign full      = fill_ff == (PTR_W+1)'(tsrp_pkg::QUEUE_DEPTH);
   assign not_empty = fill_ff != '0;
   assign head_cmd  = slot_ff[rd_ff];

   always_comb begin
      fill_in = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff   <= '0;
         rd_ff   <= '0;
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
         if (push) begin
            wr_ff <= wr_ff + 1'b1;
         end
         if (pop) begin
            rd_ff <= rd_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_cmd;
      end
   end

endmodule

>>> rtl/tsrp_back.sv
// Result sequencer: expands queued commands into result transactions.
module tsrp_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_not_empty,
   input  tsrp_pkg::cmd_type q_head,
   output logic              q_pop,
   output logic              burst_finish,
   output logic [4:0]        title_rd_idx,
   input  logic [7:0]        title_rd_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [1:0]        rsp_kind,
   output logic [4:0]        rsp_entry_index,
   output logic [5:0]        rsp_position,
   output logic [7:0]        rsp_data_byte,
   output logic [4:0]        rsp_title_length,
   output logic [5:0]        rsp_value_length,
   output logic [5:0]        rsp_entry_total,
   output logic              rsp_parse_ok,
   output logic              rsp_last_of_run
);

   tsrp_pkg::back_state_type state_ff, state_in, follow;
   tsrp_pkg::cmd_type        cmd_ff, cmd_in;
   logic [4:0]               pos_ff, pos_in;
   logic                     out_free, load, step_end;
   logic                     rsp_valid_ff;
   logic [1:0]               kind_ff, kind_in;
   logic [4:0]               idx_ff, idx_in;
   logic [5:0]               posn_ff, posn_in;
   logic [7:0]               data_ff, data_in;
   logic [4:0]               tlen_ff, tlen_in;
   logic [5:0]               vlen_ff, vlen_in;
   logic [5:0]               total_ff, total_in;
   logic                     ok_ff, ok_in;
   logic                     lor_ff, lor_in;

   // Next action of a command after the given one, in result order.
   function automatic tsrp_pkg::back_state_type next_action(
      input tsrp_pkg::cmd_type c,
      input tsrp_pkg::back_state_type from
   );
      tsrp_pkg::back_state_type r;
      r = tsrp_pkg::ST_IDLE;
      unique case (from)
         tsrp_pkg::ST_IDLE: begin
            if (c.burst)       r = tsrp_pkg::ST_BURST;
            else if (c.value)  r = tsrp_pkg::ST_VALUE;
            else if (c.commit) r = tsrp_pkg::ST_COMMIT;
            else if (c.done)   r = tsrp_pkg::ST_DONE;
         end
         tsrp_pkg::ST_BURST: begin
            if (c.value)       r = tsrp_pkg::ST_VALUE;
            else if (c.commit) r = tsrp_pkg::ST_COMMIT;
            else if (c.done)   r = tsrp_pkg::ST_DONE;
         end
         tsrp_pkg::ST_VALUE: begin
            if (c.commit)      r = tsrp_pkg::ST_COMMIT;
            else if (c.done)   r = tsrp_pkg::ST_DONE;
         end
         tsrp_pkg::ST_COMMIT: begin
            if (c.done)        r = tsrp_pkg::ST_DONE;
         end
         default: r = tsrp_pkg::ST_IDLE;
      endcase
      return r;
   endfunction

   assign out_free     = !rsp_valid_ff || rsp_ready;
   assign title_rd_idx = pos_ff;
   assign follow       = next_action(cmd_ff, state_ff);
   // A burst step ends only on its final title byte.
   assign step_end     = (state_ff != tsrp_pkg::ST_BURST) || (pos_ff == cmd_ff.burst_len - 5'd1);

   // Next state.
   always_comb begin
      state_in = state_ff;
      cmd_in   = cmd_ff;
      pos_in   = pos_ff;
      q_pop    = 1'b0;
      unique case (state_ff) inside
         tsrp_pkg::ST_IDLE: begin
            if (q_not_empty) begin
               q_pop    = 1'b1;
               cmd_in   = q_head;
               pos_in   = '0;
               state_in = next_action(q_head, tsrp_pkg::ST_IDLE);
            end
         end
         tsrp_pkg::ST_BURST, tsrp_pkg::ST_VALUE, tsrp_pkg::ST_COMMIT, tsrp_pkg::ST_DONE: begin
            if (out_free) begin
               if (step_end) begin
                  state_in = follow;
                  pos_in   = '0;
               end else begin
                  pos_in = pos_ff + 5'd1;
               end
            end
         end
         default: state_in = tsrp_pkg::ST_IDLE;
      endcase
   end

   // Outputs.
   always_comb begin
      load         = 1'b0;
      burst_finish = 1'b0;
      kind_in      = tsrp_pkg::KIND_TITLE;
      idx_in       = '0;
      posn_in      = '0;
      data_in      = '0;
      tlen_in      = '0;
      vlen_in      = '0;
      total_in     = '0;
      ok_in        = 1'b0;
      lor_in       = out_free && step_end && (follow == tsrp_pkg::ST_IDLE);
      unique case (state_ff)
         tsrp_pkg::ST_IDLE: begin
         end
         tsrp_pkg::ST_BURST: begin
            load         = out_free;
            burst_finish = out_free && step_end;
            kind_in      = tsrp_pkg::KIND_TITLE;
            idx_in       = cmd_ff.index;
            posn_in      = {1'b0, pos_ff};
            data_in      = title_rd_data;
         end
         tsrp_pkg::ST_VALUE: begin
            load    = out_free;
            kind_in = tsrp_pkg::KIND_VALUE;
            idx_in  = cmd_ff.index;
            posn_in = cmd_ff.vpos;
            data_in = cmd_ff.vdata;
         end
         tsrp_pkg::ST_COMMIT: begin
            load    = out_free;
            kind_in = tsrp_pkg::KIND_COMMIT;
            idx_in  = cmd_ff.index;
            tlen_in = cmd_ff.tlen;
            vlen_in = cmd_ff.vlen;
         end
         tsrp_pkg::ST_DONE: begin
            load     = out_free;
            kind_in  = tsrp_pkg::KIND_DONE;
            total_in = cmd_ff.total;
            ok_in    = cmd_ff.total != '0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tsrp_pkg::ST_IDLE;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
         if (out_free) begin
            rsp_valid_ff <= load;
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      if (load) begin
         kind_ff  <= kind_in;
         idx_ff   <= idx_in;
         posn_ff  <= posn_in;
         data_ff  <= data_in;
         tlen_ff  <= tlen_in;
         vlen_ff  <= vlen_in;
         total_ff <= total_in;
         ok_ff    <= ok_in;
         lor_ff   <= lor_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = kind_ff;
   assign rsp_entry_index  = idx_ff;
   assign rsp_position     = posn_ff;
   assign rsp_data_byte    = data_ff;
   assign rsp_title_length = tlen_ff;
   assign rsp_value_length = vlen_ff;
   assign rsp_entry_total  = total_ff;
   assign rsp_parse_ok     = ok_ff;
   assign rsp_last_of_run  = lor_ff;

endmodule

>>> rtl/tab_separated_record_parser.sv
// Top level of the tab-separated record parser.
//
//   channel  direction  ports                          transaction
//   req      in         req_valid/ready, in_byte/last  one text byte
//   rsp      out        rsp_valid/ready, 9 fields      one write, commit or done
//   csr      in         csr_valid/ready, index, data   one 64-bit mask word
//
// The front end takes one byte per cycle while the 4-entry command queue has room.
// The sequencer pops a command only while idle, then emits its results in order, each
// held until rsp accepts it: the title bytes of a tab, a value byte, commit, done.
// Title bytes of a new line wait until the previous title burst has drained.
// Reset is synchronous and clears line state, entry count, queue and mask words.
// A stalled rsp side fills the queue and then stalls req; csr is always ready.
module tab_separated_record_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_in_byte,
   input  logic        req_in_last,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_kind,
   output logic [4:0]  rsp_entry_index,
   output logic [5:0]  rsp_position,
   output logic [7:0]  rsp_data_byte,
   output logic [4:0]  rsp_title_length,
   output logic [5:0]  rsp_value_length,
   output logic [5:0]  rsp_entry_total,
   output logic        rsp_parse_ok,
   output logic        rsp_last_of_run,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_data
);

   logic              q_full, q_push, q_pop, q_not_empty;
   tsrp_pkg::cmd_type q_cmd, q_head;
   logic              burst_finish;
   logic [4:0]        title_rd_idx;
   logic [7:0]        title_rd_data;

   assign csr_ready = 1'b1;

   tsrp_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_in_byte   (req_in_byte),
      .req_in_last   (req_in_last),
      .csr_valid     (csr_valid),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_cmd         (q_cmd),
      .burst_finish  (burst_finish),
      .title_rd_idx  (title_rd_idx),
      .title_rd_data (title_rd_data)
   );

   tsrp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_cmd  (q_cmd),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .head_cmd  (q_head)
   );

   tsrp_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_not_empty      (q_not_empty),
      .q_head           (q_head),
      .q_pop            (q_pop),
      .burst_finish     (burst_finish),
      .title_rd_idx     (title_rd_idx),
      .title_rd_data    (title_rd_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_kind         (rsp_kind),
      .rsp_entry_index  (rsp_entry_index),
      .rsp_position     (rsp_position),
      .rsp_data_byte    (rsp_data_byte),
      .rsp_title_length (rsp_title_length),
      .rsp_value_length (rsp_value_length),
      .rsp_entry_total  (rsp_entry_total),
      .rsp_parse_ok     (rsp_parse_ok),
      .rsp_last_of_run  (rsp_last_of_run)
   );

endmodule

>>> tb/tb_tab_separated_record_parser.sv
// Self-checking testbench for the tab-separated record parser, with its result tracker.
`timescale 1ns / 1ps

package tsrp_check_pkg;

   typedef struct packed {
      logic [1:0] kind;
      logic [4:0] entry_index;
      logic [5:0] position;
      logic [7:0] data_byte;
      logic [4:0] title_length;
      logic [5:0] value_length;
      logic [5:0] entry_total;
      logic       parse_ok;
      logic       last_of_run;
   } record_result_type;

   class record_write_tracker_type;
      logic [63:0]         mask_words[4];
      tsrp_pkg::phase_type line_phase;
      logic [7:0]          title_bytes[tsrp_pkg::TITLE_CAP];
      int unsigned         title_fill;
      int unsigned         value_fill;
      int unsigned         entry_count;
      record_result_type   byte_results[$];
      record_result_type   pending_writes[$];
      int                  errors;
      int                  bytes_seen;
      int                  results_seen;
      int                  commits_seen;
      int                  dones_seen;
      bit                  limit_reached;

      function new();
         foreach (mask_words[i]) mask_words[i] = '0;
         clear_parse();
         errors = 0;
         bytes_seen = 0;
         results_seen = 0;
         commits_seen = 0;
         dones_seen = 0;
         limit_reached = 1'b0;
      endfunction

      function void clear_parse();
         line_phase = tsrp_pkg::PH_TITLE;
         title_fill = 0;
         value_fill = 0;
         entry_count = 0;
         foreach (title_bytes[i]) title_bytes[i] = '0;
      endfunction

      function void set_mask(logic [2:0] index, logic [63:0] value);
         if (index <= tsrp_pkg::CSR_MASK_3) mask_words[index] = value;
      endfunction

      function logic [7:0] mask_byte(int unsigned pos);
         int unsigned m;
         m = pos % 32;
         return mask_words[m / 8][(m % 8) * 8 +: 8];
      endfunction

      function void add_result(logic [1:0] kind, int unsigned index, int unsigned pos,
                               logic [7:0] data, int unsigned tlen, int unsigned vlen,
                               int unsigned total, bit ok);
         record_result_type r;
         r.kind         = kind;
         r.entry_index  = 5'(index);
         r.position     = 6'(pos);
         r.data_byte    = data;
         r.title_length = 5'(tlen);
         r.value_length = 6'(vlen);
         r.entry_total  = 6'(total);
         r.parse_ok     = ok;
         r.last_of_run  = 1'b0;
         byte_results.push_back(r);
      endfunction

      function void commit_line();
         add_result(tsrp_pkg::KIND_COMMIT, entry_count, 0, 8'h00, title_fill, value_fill,
                    0, 1'b0);
         entry_count++;
      endfunction

      // Work out every result caused by one accepted byte.
      function void note_byte(logic [7:0] b, bit is_last);
         bit eol;
         eol = (b == tsrp_pkg::CH_CR) || (b == tsrp_pkg::CH_LF);
         byte_results.delete();
         bytes_seen++;
         if (entry_count < tsrp_pkg::MAX_ENTRIES) begin
            if (eol) begin
               if (line_phase == tsrp_pkg::PH_VALUE) commit_line();
               line_phase = tsrp_pkg::PH_TITLE;
               title_fill = 0;
               value_fill = 0;
            end else if (line_phase == tsrp_pkg::PH_TITLE) begin
               if (b == tsrp_pkg::CH_TAB) begin
                  if (title_fill == 0) begin
                     line_phase = tsrp_pkg::PH_SKIP;
                  end else begin
                     for (int unsigned i = 0; i < title_fill; i++)
                        add_result(tsrp_pkg::KIND_TITLE, entry_count, i, title_bytes[i],
                                   0, 0, 0, 1'b0);
                     line_phase = tsrp_pkg::PH_VALUE;
                     value_fill = 0;
                  end
               end else if (title_fill < tsrp_pkg::TITLE_CAP) begin
                  title_bytes[title_fill] = b;
                  title_fill++;
               end
            end else if (line_phase == tsrp_pkg::PH_VALUE) begin
               if (value_fill < tsrp_pkg::VALUE_CAP) begin
                  add_result(tsrp_pkg::KIND_VALUE, entry_count, value_fill,
                             b ^ mask_byte(value_fill), 0, 0, 0, 1'b0);
                  value_fill++;
               end
            end
            if (is_last && line_phase == tsrp_pkg::PH_VALUE && !eol) commit_line();
         end
         if (is_last) begin
            add_result(tsrp_pkg::KIND_DONE, 0, 0, 8'h00, 0, 0, entry_count, entry_count > 0);
            if (entry_count == tsrp_pkg::MAX_ENTRIES) limit_reached = 1'b1;
            clear_parse();
         end
         if (byte_results.size() > 0) byte_results[byte_results.size() - 1].last_of_run = 1'b1;
         foreach (byte_results[i]) pending_writes.push_back(byte_results[i]);
      endfunction

      function void compare_field(string name, longint unsigned want, longint unsigned got);
         if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            errors++;
         end
      endfunction

      function void check_result(record_result_type got);
         record_result_type want;
         if (pending_writes.size() == 0) begin
            $error("result with nothing expected: kind %0d index %0d position %0d",
                   got.kind, got.entry_index, got.position);
            errors++;
            return;
         end
         want = pending_writes.pop_front();
         results_seen++;
         if (want.kind == tsrp_pkg::KIND_COMMIT) commits_seen++;
         if (want.kind == tsrp_pkg::KIND_DONE) dones_seen++;
         compare_field("kind", want.kind, got.kind);
         compare_field("entry_index", want.entry_index, got.entry_index);
         compare_field("position", want.position, got.position);
         compare_field("data_byte", want.data_byte, got.data_byte);
         compare_field("title_length", want.title_length, got.title_length);
         compare_field("value_length", want.value_length, got.value_length);
         compare_field("entry_total", want.entry_total, got.entry_total);
         compare_field("parse_ok", want.parse_ok, got.parse_ok);
         compare_field("last_of_run", want.last_of_run, got.last_of_run);
      endfunction

      function int pending();
         return pending_writes.size();
      endfunction

      function void flag_leftover();
         foreach (pending_writes[i])
            $error("missing result: kind %0d index %0d position %0d",
                   pending_writes[i].kind, pending_writes[i].entry_index,
                   pending_writes[i].position);
         errors += pending_writes.size();
      endfunction
   endclass

endpackage

module tb_tab_separated_record_parser;

   localparam int QUIET_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = 24;
   localparam int DRAIN_CYCLES  = 40;
   localparam int HOLD_CYCLES   = 250;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_in_byte = 8'h00;
   logic        req_in_last = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_kind;
   logic [4:0]  rsp_entry_index;
   logic [5:0]  rsp_position;
   logic [7:0]  rsp_data_byte;
   logic [4:0]  rsp_title_length;
   logic [5:0]  rsp_value_length;
   logic [5:0]  rsp_entry_total;
   logic        rsp_parse_ok;
   logic        rsp_last_of_run;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = tsrp_pkg::CSR_MASK_0;
   logic [63:0] csr_data = '0;

   tsrp_check_pkg::record_write_tracker_type tracker = new();
   tsrp_check_pkg::record_result_type        seen_result;
   logic [7:0]          doc_bytes[$];
   bit                  idle_on = 1'b1;
   bit                  hold_request = 1'b0;
   int                  stall_left = 0;
   int                  quiet_cycles = 0;
   int                  items_sent = 0;

   tab_separated_record_parser DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_in_byte      (req_in_byte),
      .req_in_last      (req_in_last),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_kind         (rsp_kind),
      .rsp_entry_index  (rsp_entry_index),
      .rsp_position     (rsp_position),
      .rsp_data_byte    (rsp_data_byte),
      .rsp_title_length (rsp_title_length),
      .rsp_value_length (rsp_value_length),
      .rsp_entry_total  (rsp_entry_total),
      .rsp_parse_ok     (rsp_parse_ok),
      .rsp_last_of_run  (rsp_last_of_run),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always #6 clock = ~clock;

   // Result side: check each transaction, then pick the next ready level.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         seen_result.kind         = rsp_kind;
         seen_result.entry_index  = rsp_entry_index;
         seen_result.position     = rsp_position;
         seen_result.data_byte    = rsp_data_byte;
         seen_result.title_length = rsp_title_length;
         seen_result.value_length = rsp_value_length;
         seen_result.entry_total  = rsp_entry_total;
         seen_result.parse_ok     = rsp_parse_ok;
         seen_result.last_of_run  = rsp_last_of_run;
         tracker.check_result(seen_result);
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (hold_request) begin
         hold_request = 1'b0;
         stall_left = HOLD_CYCLES - 1;
         rsp_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
         stall_left = $urandom_range(0, 17);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   task automatic send_byte(input logic [7:0] b, input bit is_last);
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_in_byte <= b;
      req_in_last <= is_last;
      do @(posedge clock); while (!req_ready);
      tracker.note_byte(b, is_last);
      items_sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
   endtask

   task automatic write_register(input logic [2:0] index, input logic [63:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      tracker.set_mask(index, value);
   endtask

   task automatic write_masks(input logic [63:0] w0, input logic [63:0] w1,
                              input logic [63:0] w2, input logic [63:0] w3);
      write_register(tsrp_pkg::CSR_MASK_0, w0);
      write_register(tsrp_pkg::CSR_MASK_1, w1);
      write_register(tsrp_pkg::CSR_MASK_2, w2);
      write_register(tsrp_pkg::CSR_MASK_3, w3);
      csr_valid <= 1'b0;
   endtask

   // Drop valid, wait out the expected results, then let queued title bytes settle.
   task automatic drain_results(input int extra);
      req_valid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   function automatic logic [7:0] plain_byte();
      logic [7:0] b;
      do b = 8'($urandom_range(0, 255));
      while (b == tsrp_pkg::CH_TAB || b == tsrp_pkg::CH_CR || b == tsrp_pkg::CH_LF);
      return b;
   endfunction

   function automatic void add_title(input int count);
      for (int i = 0; i < count; i++) doc_bytes.push_back(plain_byte());
   endfunction

   function automatic void add_value(input int count);
      for (int i = 0; i < count; i++)
         doc_bytes.push_back(($urandom_range(0, 11) == 0) ? tsrp_pkg::CH_TAB : plain_byte());
   endfunction

   function automatic void add_line_end();
      case ($urandom_range(0, 3))
         0: doc_bytes.push_back(tsrp_pkg::CH_LF);
         1: doc_bytes.push_back(tsrp_pkg::CH_CR);
         2: begin
            doc_bytes.push_back(tsrp_pkg::CH_CR);
            doc_bytes.push_back(tsrp_pkg::CH_LF);
         end
         default: begin
            doc_bytes.push_back(tsrp_pkg::CH_LF);
            doc_bytes.push_back(tsrp_pkg::CH_LF);
            doc_bytes.push_back(tsrp_pkg::CH_CR);
         end
      endcase
   endfunction

   task automatic send_doc_bytes();
      for (int i = 0; i < doc_bytes.size(); i++)
         send_byte(doc_bytes[i], i == doc_bytes.size() - 1);
   endtask

   task automatic send_document(input int line_total, input bit long_title,
                                input bit long_value);
      int title_len;
      int value_len;
      int pick;
      doc_bytes.delete();
      for (int n = 0; n < line_total; n++) begin
         pick = $urandom_range(0, 99);
         title_len = ($urandom_range(0, 11) == 0) ? $urandom_range(28, 36) : $urandom_range(1, 6);
         value_len = ($urandom_range(0, 15) == 0) ? $urandom_range(58, 66) : $urandom_range(0, 8);
         if (n == 0 && long_title) title_len = 33;
         if (n == 0 && long_value) value_len = 64;
         if (pick < 70 || (n == 0 && (long_title || long_value))) begin
            add_title(title_len);
            doc_bytes.push_back(tsrp_pkg::CH_TAB);
            add_value(value_len);
         end else if (pick < 80) begin
            add_title(title_len);
         end else if (pick < 88) begin
            doc_bytes.push_back(tsrp_pkg::CH_TAB);
            add_value(value_len);
         end else begin
            // noise: any byte at all
            for (int i = 0; i < $urandom_range(1, 6); i++)
               doc_bytes.push_back(8'($urandom_range(0, 255)));
         end
         // the final line may end on its last content byte
         if (n != line_total - 1 || $urandom_range(0, 1) == 1) add_line_end();
      end
      send_doc_bytes();
   endtask

   // More short lines than the table holds, then a line that must be ignored.
   task automatic send_full_table();
      doc_bytes.delete();
      for (int n = 0; n < tsrp_pkg::MAX_ENTRIES + 1; n++) begin
         doc_bytes.push_back(plain_byte());
         doc_bytes.push_back(tsrp_pkg::CH_TAB);
         doc_bytes.push_back(tsrp_pkg::CH_LF);
      end
      add_title(2);
      doc_bytes.push_back(tsrp_pkg::CH_TAB);
      add_value(2);
      send_doc_bytes();
   endtask

   task automatic send_random_phase(input int byte_budget, input bit long_title,
                                    input bit long_value);
      int start;
      start = items_sent;
      send_document(1, long_title, long_value);
      while (items_sent - start < byte_budget)
         send_document($urandom_range(1, 4), 1'b0, 1'b0);
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      write_masks(64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210,
                  64'h5A5A_A5A5_0F0F_F0F0, 64'h8000_0000_0000_0001);
      // empty lines from a CR/LF run, then an empty title
      send_byte(tsrp_pkg::CH_CR, 1'b0);
      send_byte(tsrp_pkg::CH_LF, 1'b0);
      send_byte(tsrp_pkg::CH_TAB, 1'b0);
      send_text("zz");
      send_byte(tsrp_pkg::CH_LF, 1'b0);
      // line without a tab
      send_text("nt");
      send_byte(tsrp_pkg::CH_LF, 1'b0);
      // later tab inside the value, CRLF end
      send_text("A");
      send_byte(tsrp_pkg::CH_TAB, 1'b0);
      send_text("B");
      send_byte(tsrp_pkg::CH_TAB, 1'b0);
      send_text("C");
      send_byte(tsrp_pkg::CH_CR, 1'b0);
      send_byte(tsrp_pkg::CH_LF, 1'b0);
      // byte extremes, line closed by the last byte
      send_byte(8'hFF, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(tsrp_pkg::CH_TAB, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h7F, 1'b1);
      // fresh parses ending with nothing committed
      send_byte(tsrp_pkg::CH_TAB, 1'b1);
      send_byte(tsrp_pkg::CH_LF, 1'b1);
      // tab as the last byte: title burst, commit and done together
      send_text("q");
      send_byte(tsrp_pkg::CH_TAB, 1'b1);
      drain_results(SETTLE_CYCLES);

      write_masks('1, '1, '1, '1);
      send_random_phase(30, 1'b1, 1'b0);
      drain_results(SETTLE_CYCLES);

      write_masks('0, '0, '0, '0);
      hold_request = 1'b1;
      send_full_table();
      drain_results(SETTLE_CYCLES);

      idle_on = 1'b0;
      write_masks({$urandom, $urandom}, {$urandom, $urandom},
                  {$urandom, $urandom}, {$urandom, $urandom});
      send_random_phase(30, 1'b0, 1'b1);
      drain_results(DRAIN_CYCLES);

      tracker.flag_leftover();
      $display("Covered %0d input bytes, %0d results checked (%0d commits, %0d done).",
               tracker.bytes_seen, tracker.results_seen, tracker.commits_seen,
               tracker.dones_seen);
      $display("Four mask settings incl. all zero and all one; entry limit %s; long hold-off run.",
               tracker.limit_reached ? "reached" : "not reached");
      if (tracker.errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

>>> filelist.f
rtl/tsrp_pkg.sv
rtl/tsrp_front.sv
rtl/tsrp_queue.sv
rtl/tsrp_back.sv
rtl/tab_separated_record_parser.sv
tb/tb_tab_separated_record_parser.sv
